### rtl/core/ptoa_pkg.sv
// Shared widths, register codes and bandwidth table for the time-on-air calculator.
package ptoa_pkg;

  // Request and result payload widths
  localparam int unsigned LEN_W = 8;
  localparam int unsigned AIR_W = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register field widths
  localparam int unsigned BW_W  = 4;
  localparam int unsigned SF_W  = 4;
  localparam int unsigned PRE_W = 16;
  localparam int unsigned CR_W  = 3;

  // Longest payload taken as given; anything longer saturates
  localparam int unsigned MAX_PAYLOAD_LEN = 255;

  // Low-data-rate optimise switches on above this symbol time (us)
  localparam int unsigned LDRO_LIMIT_US = 16380;

  // Bandwidth codes and their frequencies in Hz
  localparam int unsigned BW_CODES = 10;
  localparam int unsigned BW_HZ [BW_CODES] = '{
    7810, 10420, 15630, 20830, 31250,
    41670, 62500, 125000, 250000, 500000
  };

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 3'd0,
    CFG_BW     = 3'd1,
    CFG_SF     = 3'd2,
    CFG_PRE    = 3'd3,
    CFG_CR     = 3'd4,
    CFG_CRC    = 3'd5
  } cfg_reg_t;

endpackage

### rtl/core/ptoa_if.sv
// Request and result channel interfaces of the time-on-air calculator.
interface ptoa_query_if;
  import ptoa_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] payload_length;
  modport source (output valid, output payload_length, input ready);
  modport sink (input valid, input payload_length, output ready);
endinterface

interface ptoa_result_if;
  import ptoa_pkg::*;
  logic             valid;
  logic             ready;
  logic [AIR_W-1:0] airtime_ms;
  modport source (output valid, output airtime_ms, input ready);
  modport sink (input valid, input airtime_ms, output ready);
endinterface

### rtl/core/packet_time_on_air_calc_top.sv
// Throughput: one request per cycle while the result channel is ready; every
// stage advances when the one after it frees up. The divide by 1000 fills the
// last five stages, eight quotient bits per stage.
// A held result stalls the stages behind it; bubbles close up, nothing is lost.
// Reset (rst, synchronous) empties the pipeline and restores the register defaults.
module packet_time_on_air_calc_top (
  input  logic                           clk,
  input  logic                           rst,
  ptoa_query_if.sink                     query,
  ptoa_result_if.source                  result,
  input  logic                           cfg_write,
  input  logic [ptoa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptoa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ptoa_pkg::*;

  // Internal widths
  localparam int unsigned TS_W     = 23;             // longest symbol time in us
  localparam int unsigned PRE4_W   = PRE_W + 1;
  localparam int unsigned ACC_W    = PRE4_W + TS_W;  // time sums in us
  localparam int unsigned NUM_W    = 10;             // ceil dividend and quotient
  localparam int unsigned D_W      = 4;
  localparam int unsigned BITS_W   = 12;
  localparam int unsigned NSYM_W   = NUM_W + D_W;
  localparam int unsigned REM_W    = 10;
  localparam int unsigned MS_DIV   = 1000;
  localparam int unsigned ROUND_US = 500;
  localparam int unsigned TS_ROM_DEPTH = 1 << (BW_W + SF_W);

  // Stage map
  localparam int unsigned CDIV_STEPS = NUM_W / 2;
  localparam int unsigned DIV_STEPS  = 8;
  localparam int unsigned DIV_STAGES = ACC_W / DIV_STEPS;
  localparam int unsigned S_PREP   = 0;
  localparam int unsigned S_CDIV_A = 1;
  localparam int unsigned S_CDIV_B = 2;
  localparam int unsigned S_NSYM   = 3;
  localparam int unsigned S_TPAY   = 4;
  localparam int unsigned S_SUM    = 5;
  localparam int unsigned S_DIV0   = 6;
  localparam int unsigned STAGES   = S_DIV0 + DIV_STAGES;
  localparam int unsigned LAST     = STAGES - 1;

  typedef struct packed {
    logic              zero;   // result forced to zero
    logic [TS_W-1:0]   ts;     // symbol time, us
    logic [D_W-1:0]    d;      // SF - 2*DE
    logic [D_W-1:0]    crem;   // ceil division remainder
    logic [NUM_W-1:0]  num;    // ceil dividend, shifts into quotient
    logic [D_W-1:0]    cr4;    // coding rate + 4
    logic [ACC_W-1:0]  tpre;   // preamble count + 4, then preamble time
    logic [NSYM_W-1:0] nsym;   // payload symbols
    logic [ACC_W-1:0]  acc;    // payload time, total, then quotient
    logic [REM_W-1:0]  rem;    // divide-by-1000 remainder
  } stage_t;

  // Configuration registers
  logic              config_valid;
  logic [BW_W-1:0]   bandwidth_select;
  logic [SF_W-1:0]   spreading_factor;
  logic [PRE_W-1:0]  preamble_length;
  logic [CR_W-1:0]   cr_sel;
  logic              crc_disable;

  // Symbol time table, indexed by {bandwidth code, spreading factor}
  logic [TS_W-1:0] ts_rom [TS_ROM_DEPTH];

  // Pipeline
  stage_t              pipe      [STAGES];
  stage_t              pipe_next [STAGES];
  logic [STAGES-1:0]   pipe_vld;
  logic [STAGES-1:0]   adv;

  // Stage 0 intermediates
  logic [TS_W-1:0]     ts_lk;
  logic                de;
  logic [D_W:0]        dsig;
  logic [LEN_W-1:0]    len_sat;
  logic [BITS_W-1:0]   bits_pos;
  logic [BITS_W-1:0]   bits_clamp;
  logic [BITS_W-1:0]   bits_rnd;
  logic [NUM_W:0]      num_sum;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      config_valid     <= 1'b0;
      bandwidth_select <= BW_W'(7);
      spreading_factor <= SF_W'(7);
      preamble_length  <= PRE_W'(8);
      cr_sel           <= CR_W'(1);
      crc_disable      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ENABLE: config_valid     <= cfg_data[0];
        CFG_BW:     bandwidth_select <= cfg_data[BW_W-1:0];
        CFG_SF:     spreading_factor <= cfg_data[SF_W-1:0];
        CFG_PRE:    preamble_length  <= cfg_data[PRE_W-1:0];
        CFG_CR:     cr_sel           <= cfg_data[CR_W-1:0];
        CFG_CRC:    crc_disable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Build the symbol time table at elaboration
  for (genvar g = 0; g < TS_ROM_DEPTH; g++) begin : g_ts
    localparam int unsigned BwCode = g / (1 << SF_W);
    localparam int unsigned SfCode = g % (1 << SF_W);
    if (BwCode < BW_CODES) begin : g_valid
      localparam longint unsigned BwHz = BW_HZ[BwCode];
      localparam longint unsigned TsUs = (64'd1000000 << SfCode) / BwHz;
      assign ts_rom[g] = TS_W'(TsUs);
    end else begin : g_bad
      assign ts_rom[g] = '0;
    end
  end

  // Advance a stage when it is empty or the next one moves
  always_comb begin
    adv[LAST] = !pipe_vld[LAST] || result.ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      adv[i] = !pipe_vld[i] || adv[i+1];
    end
  end

  assign query.ready = adv[S_PREP];

  // Stage 0: look up symbol time, derive divisor and bit count
  always_comb begin
    ts_lk    = ts_rom[{bandwidth_select, spreading_factor}];
    de       = ts_lk > TS_W'(LDRO_LIMIT_US);
    dsig     = {1'b0, spreading_factor} - {{(D_W-1){1'b0}}, de, 1'b0};
    len_sat  = (query.payload_length > LEN_W'(MAX_PAYLOAD_LEN)) ?
               LEN_W'(MAX_PAYLOAD_LEN) : query.payload_length;
    bits_pos = {1'b0, len_sat, 3'b000} + BITS_W'(28) +
               (crc_disable ? BITS_W'(0) : BITS_W'(16));
    bits_clamp = (bits_pos < BITS_W'({spreading_factor, 2'b00})) ? '0 :
                 bits_pos - BITS_W'({spreading_factor, 2'b00});
    bits_rnd = bits_clamp + BITS_W'(3);
    num_sum  = {1'b0, bits_rnd[BITS_W-1:2]} + (NUM_W+1)'(dsig[D_W-1:0]) - (NUM_W+1)'(1);
  end

  // Next value of every stage
  always_comb begin
    logic [D_W:0]         t5;
    logic [REM_W:0]       t11;
    logic [NSYM_W-1:0]    sym_prod;
    logic [NSYM_W+TS_W-1:0] pay_prod;

    // Stage 0
    pipe_next[S_PREP].zero = !config_valid ||
                             (bandwidth_select >= BW_W'(BW_CODES)) ||
                             (spreading_factor == '0) ||
                             dsig[D_W] || (dsig == '0);
    pipe_next[S_PREP].ts   = ts_lk;
    pipe_next[S_PREP].d    = dsig[D_W-1:0];
    pipe_next[S_PREP].crem = '0;
    pipe_next[S_PREP].num  = num_sum[NUM_W-1:0];
    pipe_next[S_PREP].cr4  = D_W'({1'b0, cr_sel}) + D_W'(4);
    pipe_next[S_PREP].tpre = ACC_W'(preamble_length) + ACC_W'(4);
    pipe_next[S_PREP].nsym = '0;
    pipe_next[S_PREP].acc  = '0;
    pipe_next[S_PREP].rem  = '0;

    // Carry everything forward by default
    for (int i = 1; i < STAGES; i++) begin
      pipe_next[i] = pipe[i-1];
    end

    // Stages 1-2: ceil division, five quotient bits each
    for (int s = S_CDIV_A; s <= S_CDIV_B; s++) begin
      for (int k = 0; k < CDIV_STEPS; k++) begin
        t5 = {pipe_next[s].crem, pipe_next[s].num[NUM_W-1]};
        if (t5 >= {1'b0, pipe_next[s].d}) begin
          pipe_next[s].crem = D_W'(t5 - {1'b0, pipe_next[s].d});
          pipe_next[s].num  = {pipe_next[s].num[NUM_W-2:0], 1'b1};
        end else begin
          pipe_next[s].crem = t5[D_W-1:0];
          pipe_next[s].num  = {pipe_next[s].num[NUM_W-2:0], 1'b0};
        end
      end
    end

    // Stage 1: preamble symbols times symbol time
    pipe_next[S_CDIV_A].tpre = pipe[S_CDIV_A-1].tpre[PRE4_W-1:0] * pipe[S_CDIV_A-1].ts;

    // Stage 2: add the quarter symbol
    pipe_next[S_CDIV_B].tpre = pipe[S_CDIV_B-1].tpre +
                               ACC_W'(pipe[S_CDIV_B-1].ts[TS_W-1:2]);

    // Stage 3: payload symbol count
    sym_prod = pipe[S_NSYM-1].num * pipe[S_NSYM-1].cr4;
    pipe_next[S_NSYM].nsym = sym_prod + NSYM_W'(8);

    // Stage 4: payload time, full product width before widening
    pay_prod = pipe[S_TPAY-1].nsym * pipe[S_TPAY-1].ts;
    pipe_next[S_TPAY].acc = ACC_W'(pay_prod);

    // Stage 5: total with rounding offset
    pipe_next[S_SUM].acc = pipe[S_SUM-1].tpre + pipe[S_SUM-1].acc + ACC_W'(ROUND_US);
    pipe_next[S_SUM].rem = '0;

    // Stages 6-10: divide by 1000, eight quotient bits each
    for (int s = S_DIV0; s < STAGES; s++) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        t11 = {pipe_next[s].rem, pipe_next[s].acc[ACC_W-1]};
        if (t11 >= (REM_W+1)'(MS_DIV)) begin
          pipe_next[s].rem = REM_W'(t11 - (REM_W+1)'(MS_DIV));
          pipe_next[s].acc = {pipe_next[s].acc[ACC_W-2:0], 1'b1};
        end else begin
          pipe_next[s].rem = t11[REM_W-1:0];
          pipe_next[s].acc = {pipe_next[s].acc[ACC_W-2:0], 1'b0};
        end
      end
    end
  end

  // Advance valid bits; reset empties the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= '0;
    end else begin
      if (adv[S_PREP]) pipe_vld[S_PREP] <= query.valid;
      for (int i = 1; i < STAGES; i++) begin
        if (adv[i]) pipe_vld[i] <= pipe_vld[i-1];
      end
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    for (int i = 0; i < STAGES; i++) begin
      if (adv[i]) pipe[i] <= pipe_next[i];
    end
  end

  // Drive the result
  assign result.valid      = pipe_vld[LAST];
  assign result.airtime_ms = pipe[LAST].zero ? '0 : pipe[LAST].acc[AIR_W-1:0];

`ifndef ASSERT_OFF
  a_reset_empties: assert property (@(posedge clk) rst |=> (pipe_vld == '0))
    else $error("pipeline not empty after reset");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !query.ready |-> (&pipe_vld))
    else $error("request refused while a stage is free");

  a_ceil_rem: assert property (@(posedge clk) disable iff (rst)
    (pipe_vld[S_CDIV_B] && !pipe[S_CDIV_B].zero) |->
    (pipe[S_CDIV_B].crem < pipe[S_CDIV_B].d))
    else $error("ceil division remainder out of range");

  a_ms_rem: assert property (@(posedge clk) disable iff (rst)
    pipe_vld[LAST] |-> (pipe[LAST].rem < REM_W'(MS_DIV)))
    else $error("millisecond division remainder out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (pipe_vld[S_SUM] && !adv[S_SUM]) |=>
    (pipe_vld[S_SUM] && $stable(pipe[S_SUM].acc)))
    else $error("stalled stage lost its request");
`endif

endmodule
